// ===== rtl/core/scaled_glyph_rasteriser_assert.svh =====
// Assertion macros for the glyph rasteriser modules; only sgr_back includes them.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SCALED_GLYPH_RASTERISER_ASSERT_SVH
`define SCALED_GLYPH_RASTERISER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SGR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgr: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SGR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgr: next-cycle check failed");

`endif

// ===== rtl/core/sgr_pkg.sv =====
package sgr_pkg;

    localparam int FB_WIDTH    = 640;
    localparam int FB_HEIGHT   = 480;
    localparam int CODE_LO     = 32;
    localparam int CODE_HI     = 95;
    localparam int LOWER_A     = 97;
    localparam int LOWER_Z     = 122;
    localparam int CASE_OFFSET = 32;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
    localparam int GLYPH_IDX_W = 6;
    localparam int COORD_W     = 15;
    localparam int SCALE_W     = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph;
        logic signed [12:0]    pos_x;
        logic signed [12:0]    pos_y;
        logic [SCALE_W-1:0]    scale;
        logic [31:0]           colour;
    } sgr_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sgr_qstat_t;

    typedef struct packed {
        logic               ok;
        logic [10:0]        pos;
        logic [SCALE_W-1:0] len;
    } sgr_span_t;

    function automatic logic [GLYPH_BITS-1:0] pack_rows(
        input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
        input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
        input logic [4:0] r6);
        return {r0, r1, r2, r3, r4, r5, r6};
    endfunction

    // Top row sits in the most significant bits, leftmost column first.
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
        logic [GLYPH_BITS-1:0] g;
        case (idx)
            6'd0:  g = pack_rows(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
            6'd1:  g = pack_rows(5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4);
            6'd2:  g = pack_rows(5'd10, 5'd10, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
            6'd3:  g = pack_rows(5'd10, 5'd31, 5'd10, 5'd31, 5'd10, 5'd0, 5'd0);
            6'd4:  g = pack_rows(5'd4, 5'd15, 5'd20, 5'd14, 5'd5, 5'd30, 5'd4);
            6'd5:  g = pack_rows(5'd25, 5'd26, 5'd2, 5'd4, 5'd8, 5'd11, 5'd19);
            6'd6:  g = pack_rows(5'd12, 5'd18, 5'd20, 5'd8, 5'd21, 5'd18, 5'd13);
            6'd7:  g = pack_rows(5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
            6'd8:  g = pack_rows(5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2);
            6'd9:  g = pack_rows(5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8);
            6'd10: g = pack_rows(5'd0, 5'd10, 5'd4, 5'd31, 5'd4, 5'd10, 5'd0);
            6'd11: g = pack_rows(5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0);
            6'd12: g = pack_rows(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4, 5'd8);
            6'd13: g = pack_rows(5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0);
            6'd14: g = pack_rows(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd4);
            6'd15: g = pack_rows(5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16);
            6'd16: g = pack_rows(5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14);
            6'd17: g = pack_rows(5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14);
            6'd18: g = pack_rows(5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31);
            6'd19: g = pack_rows(5'd31, 5'd2, 5'd4, 5'd2, 5'd1, 5'd17, 5'd14);
            6'd20: g = pack_rows(5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2);
            6'd21: g = pack_rows(5'd31, 5'd16, 5'd30, 5'd1, 5'd1, 5'd17, 5'd14);
            6'd22: g = pack_rows(5'd6, 5'd8, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14);
            6'd23: g = pack_rows(5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8);
            6'd24: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14);
            6'd25: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd2, 5'd12);
            6'd26: g = pack_rows(5'd0, 5'd4, 5'd0, 5'd0, 5'd0, 5'd4, 5'd0);
            6'd27: g = pack_rows(5'd0, 5'd4, 5'd0, 5'd0, 5'd0, 5'd4, 5'd8);
            6'd28: g = pack_rows(5'd2, 5'd4, 5'd8, 5'd16, 5'd8, 5'd4, 5'd2);
            6'd29: g = pack_rows(5'd0, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0);
            6'd30: g = pack_rows(5'd8, 5'd4, 5'd2, 5'd1, 5'd2, 5'd4, 5'd8);
            6'd31: g = pack_rows(5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4);
            6'd32: g = pack_rows(5'd14, 5'd17, 5'd1, 5'd13, 5'd21, 5'd21, 5'd14);
            6'd33: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            6'd34: g = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30);
            6'd35: g = pack_rows(5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14);
            6'd36: g = pack_rows(5'd28, 5'd18, 5'd17, 5'd17, 5'd17, 5'd18, 5'd28);
            6'd37: g = pack_rows(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31);
            6'd38: g = pack_rows(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16);
            6'd39: g = pack_rows(5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15);
            6'd40: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            6'd41: g = pack_rows(5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14);
            6'd42: g = pack_rows(5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12);
            6'd43: g = pack_rows(5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17);
            6'd44: g = pack_rows(5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31);
            6'd45: g = pack_rows(5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17);
            6'd46: g = pack_rows(5'd17, 5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17);
            6'd47: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            6'd48: g = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16);
            6'd49: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13);
            6'd50: g = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17);
            6'd51: g = pack_rows(5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30);
            6'd52: g = pack_rows(5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4);
            6'd53: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            6'd54: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4);
            6'd55: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10);
            6'd56: g = pack_rows(5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17);
            6'd57: g = pack_rows(5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4);
            6'd58: g = pack_rows(5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31);
            6'd59: g = pack_rows(5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14);
            6'd60: g = pack_rows(5'd16, 5'd8, 5'd8, 5'd4, 5'd2, 5'd2, 5'd1);
            6'd61: g = pack_rows(5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14);
            6'd62: g = pack_rows(5'd4, 5'd10, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0);
            default: g = pack_rows(5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31);
        endcase
        return g;
    endfunction

    function automatic sgr_span_t clip_span(
        input logic signed [COORD_W-1:0] p,
        input logic [SCALE_W-1:0]        len,
        input logic signed [COORD_W-1:0] lim);
        logic signed [COORD_W-1:0] pl;
        logic signed [COORD_W-1:0] ll;
        sgr_span_t                 r;
        pl = p;
        ll = $signed({{(COORD_W-SCALE_W){1'b0}}, len});
        if (p < 0)
        begin
            ll = ll + p;
            pl = '0;
        end
        if (pl + ll > lim)
        begin
            ll = lim - pl;
        end
        r.ok  = (ll > 0);
        r.pos = pl[10:0];
        r.len = ll[SCALE_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/scaled_glyph_rasteriser.sv =====
// Draws one 5x7 font character as a run of filled rectangles, one per lit font cell,
// each scaled to scale by scale pixels and clipped to the 640 by 480 framebuffer.
// A character is taken on a transfer when start is high and busy is low; lower-case
// letters are folded to upper case, and a code outside the printable range or a zero
// scale is taken but draws nothing. Up to two characters wait in a queue ahead of the
// scanner, and busy is high while that queue is full. For each drawable character the
// scanner loads it, steps through all 35 font cells in turn, and then sends the final
// rectangle. Rectangles appear at most one per cycle on strobe, in row
// then column order, and the receiver cannot hold them off; the last rectangle of a
// character carries last. A character whose squares are all clipped away gives no
// rectangle at all.
module scaled_glyph_rasteriser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         char_code,
    input  logic signed [12:0] pos_x,
    input  logic signed [12:0] pos_y,
    input  logic [4:0]         scale,
    input  logic [31:0]        colour,
    output logic               strobe,
    output logic [10:0]        rect_x,
    output logic [10:0]        rect_y,
    output logic [4:0]         rect_w,
    output logic [4:0]         rect_h,
    output logic [31:0]        fill_colour,
    output logic               last
);

    sgr_pkg::sgr_item_t  push_item;
    sgr_pkg::sgr_item_t  head;
    sgr_pkg::sgr_qstat_t qstat;
    logic                push;
    logic                pop;

    sgr_front u_front (
        .start     (start),
        .char_code (char_code),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .scale     (scale),
        .colour    (colour),
        .qstat     (qstat),
        .busy      (busy),
        .push      (push),
        .item      (push_item)
    );

    sgr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    sgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .strobe      (strobe),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .fill_colour (fill_colour),
        .last        (last)
    );

endmodule

// ===== rtl/core/sgr_front.sv =====
module sgr_front (
    input  logic                start,
    input  logic [7:0]          char_code,
    input  logic signed [12:0]  pos_x,
    input  logic signed [12:0]  pos_y,
    input  logic [4:0]          scale,
    input  logic [31:0]         colour,
    input  sgr_pkg::sgr_qstat_t qstat,
    output logic                busy,
    output logic                push,
    output sgr_pkg::sgr_item_t  item
);

    logic [7:0]                          code_fold;
    logic [7:0]                          idx_wide;
    logic [sgr_pkg::GLYPH_IDX_W-1:0]     glyph_idx;
    logic                                drawable;

    always_comb
    begin
        code_fold = char_code;
        if (char_code >= 8'(sgr_pkg::LOWER_A) && char_code <= 8'(sgr_pkg::LOWER_Z))
        begin
            code_fold = char_code - 8'(sgr_pkg::CASE_OFFSET);
        end
        idx_wide  = code_fold - 8'(sgr_pkg::CODE_LO);
        glyph_idx = idx_wide[sgr_pkg::GLYPH_IDX_W-1:0];
        drawable  = (code_fold >= 8'(sgr_pkg::CODE_LO)) &&
                    (code_fold <= 8'(sgr_pkg::CODE_HI)) && (scale != '0);
    end

    // Characters outside the printable range or with a zero scale are dropped at the transfer.
    assign busy        = qstat.full;
    assign push        = start && !qstat.full && drawable;
    assign item.glyph  = sgr_pkg::glyph_bits(glyph_idx);
    assign item.pos_x  = pos_x;
    assign item.pos_y  = pos_y;
    assign item.scale  = scale;
    assign item.colour = colour;

endmodule

// ===== rtl/core/sgr_queue.sv =====
module sgr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sgr_pkg::sgr_item_t  push_item,
    input  logic                pop,
    output sgr_pkg::sgr_item_t  head,
    output sgr_pkg::sgr_qstat_t qstat
);

    sgr_pkg::sgr_item_t               mem_reg [sgr_pkg::QUEUE_DEPTH];
    logic [sgr_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sgr_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [sgr_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sgr_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [sgr_pkg::QCNT_W-1:0]       count_reg;
    logic [sgr_pkg::QCNT_W-1:0]       count_next;

    assign qstat.full  = (count_reg == sgr_pkg::QCNT_W'(sgr_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sgr_pkg::QPTR_W'(sgr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sgr_pkg::QPTR_W'(sgr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/sgr_back.sv =====
`include "scaled_glyph_rasteriser_assert.svh"

module sgr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sgr_pkg::sgr_item_t  head,
    input  sgr_pkg::sgr_qstat_t qstat,
    output logic                pop,
    output logic                strobe,
    output logic [10:0]         rect_x,
    output logic [10:0]         rect_y,
    output logic [4:0]          rect_w,
    output logic [4:0]          rect_h,
    output logic [31:0]         fill_colour,
    output logic                last
);

    typedef enum logic [1:0] {IDLE, SCAN, FLUSH} state_t;

    localparam logic signed [sgr_pkg::COORD_W-1:0] FbW = sgr_pkg::COORD_W'(sgr_pkg::FB_WIDTH);
    localparam logic signed [sgr_pkg::COORD_W-1:0] FbH = sgr_pkg::COORD_W'(sgr_pkg::FB_HEIGHT);

    state_t                                state_reg, state_next;
    logic [sgr_pkg::GLYPH_BITS-1:0]        glyph_reg, glyph_next;
    logic signed [sgr_pkg::COORD_W-1:0]    px_reg, px_next;
    logic signed [sgr_pkg::COORD_W-1:0]    cx_reg, cx_next;
    logic signed [sgr_pkg::COORD_W-1:0]    cy_reg, cy_next;
    logic [sgr_pkg::SCALE_W-1:0]           s_reg, s_next;
    logic [31:0]                           colour_reg, colour_next;
    logic [2:0]                            col_reg, col_next;
    logic [2:0]                            row_reg, row_next;
    logic                                  pend_valid_reg, pend_valid_next;
    logic [10:0]                           pend_x_reg, pend_x_next;
    logic [10:0]                           pend_y_reg, pend_y_next;
    logic [4:0]                            pend_w_reg, pend_w_next;
    logic [4:0]                            pend_h_reg, pend_h_next;
    logic                                  strobe_reg, strobe_next;
    logic [10:0]                           rect_x_reg, rect_x_next;
    logic [10:0]                           rect_y_reg, rect_y_next;
    logic [4:0]                            rect_w_reg, rect_w_next;
    logic [4:0]                            rect_h_reg, rect_h_next;
    logic [31:0]                           fill_colour_reg, fill_colour_next;
    logic                                  last_reg, last_next;
    logic signed [sgr_pkg::COORD_W-1:0]    s_ext;
    sgr_pkg::sgr_span_t                    span_x;
    sgr_pkg::sgr_span_t                    span_y;
    logic                                  take;

    assign s_ext  = $signed({{(sgr_pkg::COORD_W-sgr_pkg::SCALE_W){1'b0}}, s_reg});
    assign span_x = sgr_pkg::clip_span(cx_reg, s_reg, FbW);
    assign span_y = sgr_pkg::clip_span(cy_reg, s_reg, FbH);
    assign take   = glyph_reg[sgr_pkg::GLYPH_BITS-1] && span_x.ok && span_y.ok;

    always_comb
    begin
        state_next       = state_reg;
        glyph_next       = glyph_reg;
        px_next          = px_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        s_next           = s_reg;
        colour_next      = colour_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        pend_valid_next  = pend_valid_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_w_next      = pend_w_reg;
        pend_h_next      = pend_h_reg;
        strobe_next      = 1'b0;
        rect_x_next      = rect_x_reg;
        rect_y_next      = rect_y_reg;
        rect_w_next      = rect_w_reg;
        rect_h_next      = rect_h_reg;
        fill_colour_next = fill_colour_reg;
        last_next        = 1'b0;
        pop              = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop         = 1'b1;
                    glyph_next  = head.glyph;
                    px_next     = sgr_pkg::COORD_W'(head.pos_x);
                    cx_next     = sgr_pkg::COORD_W'(head.pos_x);
                    cy_next     = sgr_pkg::COORD_W'(head.pos_y);
                    s_next      = head.scale;
                    colour_next = head.colour;
                    col_next    = '0;
                    row_next    = '0;
                    state_next  = SCAN;
                end
            end
            SCAN:
            begin
                // A found square waits one slot so that the final one can carry last.
                if (take)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next      = 1'b1;
                        rect_x_next      = pend_x_reg;
                        rect_y_next      = pend_y_reg;
                        rect_w_next      = pend_w_reg;
                        rect_h_next      = pend_h_reg;
                        fill_colour_next = colour_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_x_next     = span_x.pos;
                    pend_y_next     = span_y.pos;
                    pend_w_next     = span_x.len;
                    pend_h_next     = span_y.len;
                end
                glyph_next = glyph_reg << 1;
                if (col_reg == 3'(sgr_pkg::GLYPH_COLS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    cx_next  = px_reg;
                    cy_next  = cy_reg + s_ext;
                    if (row_reg == 3'(sgr_pkg::GLYPH_ROWS - 1))
                    begin
                        state_next = FLUSH;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    cx_next  = cx_reg + s_ext;
                end
            end
            FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    strobe_next      = 1'b1;
                    rect_x_next      = pend_x_reg;
                    rect_y_next      = pend_y_reg;
                    rect_w_next      = pend_w_reg;
                    rect_h_next      = pend_h_reg;
                    fill_colour_next = colour_reg;
                    last_next        = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            glyph_reg       <= '0;
            px_reg          <= '0;
            cx_reg          <= '0;
            cy_reg          <= '0;
            s_reg           <= '0;
            colour_reg      <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            pend_valid_reg  <= 1'b0;
            pend_x_reg      <= '0;
            pend_y_reg      <= '0;
            pend_w_reg      <= '0;
            pend_h_reg      <= '0;
            strobe_reg      <= 1'b0;
            rect_x_reg      <= '0;
            rect_y_reg      <= '0;
            rect_w_reg      <= '0;
            rect_h_reg      <= '0;
            fill_colour_reg <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            glyph_reg       <= glyph_next;
            px_reg          <= px_next;
            cx_reg          <= cx_next;
            cy_reg          <= cy_next;
            s_reg           <= s_next;
            colour_reg      <= colour_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            pend_valid_reg  <= pend_valid_next;
            pend_x_reg      <= pend_x_next;
            pend_y_reg      <= pend_y_next;
            pend_w_reg      <= pend_w_next;
            pend_h_reg      <= pend_h_next;
            strobe_reg      <= strobe_next;
            rect_x_reg      <= rect_x_next;
            rect_y_reg      <= rect_y_next;
            rect_w_reg      <= rect_w_next;
            rect_h_reg      <= rect_h_next;
            fill_colour_reg <= fill_colour_next;
            last_reg        <= last_next;
        end
    end

    assign strobe      = strobe_reg;
    assign rect_x      = rect_x_reg;
    assign rect_y      = rect_y_reg;
    assign rect_w      = rect_w_reg;
    assign rect_h      = rect_h_reg;
    assign fill_colour = fill_colour_reg;
    assign last        = last_reg;

    `SGR_ASSERT_IMP(a_rect_nonempty, strobe_reg, (rect_w_reg != '0) && (rect_h_reg != '0))
    `SGR_ASSERT_IMP(a_rect_inside, strobe_reg, (rect_x_reg < 11'(sgr_pkg::FB_WIDTH)) && (rect_y_reg < 11'(sgr_pkg::FB_HEIGHT)))
    `SGR_ASSERT_NXT(a_gap_after_last, strobe_reg && last_reg, !strobe_reg)
    `SGR_ASSERT_IMP(a_idle_no_pending, state_reg == IDLE, !pend_valid_reg)

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W = 640;
    localparam int SCREEN_H = 480;
    localparam int FIRST_CODE = 32;
    localparam int LAST_CODE = 95;
    localparam int LOWER_FIRST = 97;
    localparam int LOWER_LAST = 122;
    localparam int CASE_SHIFT = 32;
    localparam int ROWS = 7;
    localparam int COLS = 5;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        bit [10:0] x;
        bit [10:0] y;
        bit [4:0]  w;
        bit [4:0]  h;
        bit [31:0] colour;
        bit        last;
    } rect_t;

    bit [4:0] font_rows [0:447] = '{
        0,0,0,0,0,0,0,        4,4,4,4,4,0,4,        10,10,0,0,0,0,0,
        10,31,10,31,10,0,0,   4,15,20,14,5,30,4,    25,26,2,4,8,11,19,
        12,18,20,8,21,18,13,  4,4,0,0,0,0,0,        2,4,8,8,8,4,2,
        8,4,2,2,2,4,8,        0,10,4,31,4,10,0,     0,4,4,31,4,4,0,
        0,0,0,0,0,4,8,        0,0,0,31,0,0,0,       0,0,0,0,0,0,4,
        1,2,2,4,8,8,16,       14,17,19,21,25,17,14, 4,12,4,4,4,4,14,
        14,17,1,2,4,8,31,     31,2,4,2,1,17,14,     2,6,10,18,31,2,2,
        31,16,30,1,1,17,14,   6,8,16,30,17,17,14,   31,1,2,4,8,8,8,
        14,17,17,14,17,17,14, 14,17,17,15,1,2,12,   0,4,0,0,0,4,0,
        0,4,0,0,0,4,8,        2,4,8,16,8,4,2,       0,0,31,0,31,0,0,
        8,4,2,1,2,4,8,        14,17,1,2,4,0,4,      14,17,1,13,21,21,14,
        14,17,17,31,17,17,17, 30,17,17,30,17,17,30, 14,17,16,16,16,17,14,
        28,18,17,17,17,18,28, 31,16,16,30,16,16,31, 31,16,16,30,16,16,16,
        14,17,16,23,17,17,15, 17,17,17,31,17,17,17, 14,4,4,4,4,4,14,
        7,2,2,2,2,18,12,      17,18,20,24,20,18,17, 16,16,16,16,16,16,31,
        17,27,21,21,17,17,17, 17,17,25,21,19,17,17, 14,17,17,17,17,17,14,
        30,17,17,30,16,16,16, 14,17,17,17,21,18,13, 30,17,17,30,20,18,17,
        15,16,16,14,1,1,30,   31,4,4,4,4,4,4,       17,17,17,17,17,17,14,
        17,17,17,17,17,10,4,  17,17,17,21,21,21,10, 17,17,10,4,10,17,17,
        17,17,10,4,4,4,4,     31,1,2,4,8,16,31,     14,8,8,8,8,8,14,
        16,8,8,4,2,2,1,       14,2,2,2,2,2,14,      4,10,17,0,0,0,0,
        0,0,0,0,0,0,31
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [7:0]         char_code;
    logic signed [12:0] pos_x;
    logic signed [12:0] pos_y;
    logic [4:0]         scale;
    logic [31:0]        colour;
    logic               strobe;
    logic [10:0]        rect_x;
    logic [10:0]        rect_y;
    logic [4:0]         rect_w;
    logic [4:0]         rect_h;
    logic [31:0]        fill_colour;
    logic               last;

    rect_t pending_rects[$];
    rect_t want;
    int    chars_sent;
    int    rects_seen;
    int    mismatches;
    bit    gaps_on;

    scaled_glyph_rasteriser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .char_code   (char_code),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .scale       (scale),
        .colour      (colour),
        .strobe      (strobe),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .fill_colour (fill_colour),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit clip_to_screen(inout int p, inout int len, input int lim);
        if (p < 0)
        begin
            len = len + p;
            p = 0;
        end
        if (p + len > lim)
        begin
            len = lim - p;
        end
        return len > 0;
    endfunction

    function automatic void rasterise_char(input bit [7:0] code_in, input bit signed [12:0] px,
                                           input bit signed [12:0] py, input bit [4:0] s,
                                           input bit [31:0] col);
        int    code;
        int    x;
        int    y;
        int    w;
        int    h;
        int    queued;
        bit [4:0] bits;
        rect_t rect;
        code = int'(code_in);
        queued = pending_rects.size();
        if (code >= LOWER_FIRST && code <= LOWER_LAST)
        begin
            code = code - CASE_SHIFT;
        end
        if (code < FIRST_CODE || code > LAST_CODE || s == 0)
        begin
            return;
        end
        for (int r = 0; r < ROWS; r++)
        begin
            bits = font_rows[(code - FIRST_CODE) * ROWS + r];
            for (int c = 0; c < COLS; c++)
            begin
                if (!bits[COLS - 1 - c])
                begin
                    continue;
                end
                x = int'(px) + c * int'(s);
                y = int'(py) + r * int'(s);
                w = int'(s);
                h = int'(s);
                if (!clip_to_screen(x, w, SCREEN_W))
                begin
                    continue;
                end
                if (!clip_to_screen(y, h, SCREEN_H))
                begin
                    continue;
                end
                rect.x = x[10:0];
                rect.y = y[10:0];
                rect.w = w[4:0];
                rect.h = h[4:0];
                rect.colour = col;
                rect.last = 1'b0;
                pending_rects.push_back(rect);
            end
        end
        if (pending_rects.size() > queued)
        begin
            pending_rects[pending_rects.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic send_char(input bit [7:0] code, input bit signed [12:0] px,
                             input bit signed [12:0] py, input bit [4:0] s,
                             input bit [31:0] col);
        while (gaps_on && $urandom_range(99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        char_code <= code;
        pos_x     <= px;
        pos_y     <= py;
        scale     <= s;
        colour    <= col;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        rasterise_char(code, px, py, s, col);
        chars_sent++;
    endtask

    task automatic compare_field(input string name, input bit [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            rects_seen++;
            if (pending_rects.size() == 0)
            begin
                $display("%0t: rectangle expected none actual x=%0d y=%0d w=%0d h=%0d",
                         $time, rect_x, rect_y, rect_w, rect_h);
                mismatches++;
            end
            else
            begin
                want = pending_rects.pop_front();
                compare_field("rect_x", 32'(want.x), 32'(rect_x));
                compare_field("rect_y", 32'(want.y), 32'(rect_y));
                compare_field("rect_w", 32'(want.w), 32'(rect_w));
                compare_field("rect_h", 32'(want.h), 32'(rect_h));
                compare_field("fill_colour", want.colour, fill_colour);
                compare_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    task automatic test_directed_glyphs();
        send_char("B", 0, 0, 1, 32'h0000_0000);
        send_char("#", 100, 50, 31, 32'hFFFF_FFFF);
        send_char("a", 10, 10, 2, 32'h1234_5678);
        send_char("z", 600, 440, 10, 32'hA5A5_5A5A);
        send_char("{", 200, 200, 4, 32'h0F0F_0F0F);
        send_char(8'd255, 200, 200, 4, 32'h0000_0001);
        send_char(8'd0, 200, 200, 4, 32'h8000_0000);
        send_char(8'd31, 200, 200, 4, 32'hDEAD_BEEF);
        send_char(8'd96, 200, 200, 4, 32'hCAFE_F00D);
        send_char(" ", 300, 300, 5, 32'h7777_7777);
        send_char("_", 0, 473, 1, 32'h5555_AAAA);
        send_char("@", 300, 300, 0, 32'h0101_0101);
        send_char("8", -13'sd4096, -13'sd4096, 31, 32'hFFFF_0000);
        send_char("8", 13'sd4095, 13'sd4095, 31, 32'h0000_FFFF);
        send_char("W", -20, -20, 8, 32'h2468_ACE0);
        send_char("M", 635, 475, 31, 32'h1357_9BDF);
        send_char("H", 640, 0, 1, 32'h0000_00FF);
        send_char("H", -5, 0, 1, 32'h0000_FF00);
        send_char("H", -4, 0, 1, 32'h00FF_0000);
        send_char("!", 320, 240, 31, 32'hFF00_0000);
        send_char("/", 609, 449, 31, 32'h3C3C_3C3C);
        send_char("A", 0, -31, 31, 32'h9999_9999);
        send_char("^", 620, 10, 4, 32'h4242_4242);
    endtask

    task automatic test_onscreen_text(input int count);
        int xv;
        int yv;
        bit [7:0] code;
        bit [4:0] s;
        repeat (count)
        begin
            if ($urandom_range(99) < 80)
            begin
                code = 8'($urandom_range(LOWER_LAST, FIRST_CODE));
            end
            else
            begin
                code = 8'($urandom_range(255));
            end
            if ($urandom_range(99) < 90)
            begin
                s = 5'($urandom_range(12, 1));
            end
            else
            begin
                s = 5'($urandom_range(31));
            end
            xv = int'($urandom_range(760)) - 60;
            yv = int'($urandom_range(580)) - 60;
            send_char(code, xv[12:0], yv[12:0], s, $urandom());
        end
    endtask

    task automatic test_random_bytes(input int count);
        bit [31:0] xv;
        bit [31:0] yv;
        repeat (count)
        begin
            xv = $urandom();
            yv = $urandom();
            send_char(8'($urandom_range(255)), xv[12:0], yv[12:0],
                      5'($urandom_range(31)), $urandom());
        end
    endtask

    task automatic test_burst(input int count);
        gaps_on = 1'b0;
        test_onscreen_text(count);
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     <= 1'b0;
        char_code <= '0;
        pos_x     <= '0;
        pos_y     <= '0;
        scale     <= '0;
        colour    <= '0;
        gaps_on    = 1'b1;
        chars_sent = 0;
        rects_seen = 0;
        mismatches = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_glyphs();
        test_onscreen_text(120);
        test_random_bytes(40);
        test_burst(40);

        start <= 1'b0;
        while (pending_rects.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drew %0d characters (directed, on-screen, random and back-to-back).",
                 chars_sent);
        $display("Checked %0d rectangles against the predicted glyph squares.", rects_seen);
        if (mismatches == 0 && pending_rects.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out waiting for the rasteriser.");
        $display("Mismatches found");
        $finish;
    end
endmodule
